FILE: rtl/core/fct_pkg.sv
package fct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SLOT_NUM_W = 6;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic REG_TCP_TIMEOUT = 1'b0;
   localparam logic REG_UDP_TIMEOUT = 1'b1;

   typedef struct packed {
      logic        mode;
      logic        trackable;
      logic        is_ipv6;
      logic [7:0]  l4_protocol;
      logic [63:0] src_addr_upper;
      logic [63:0] src_addr_lower;
      logic [63:0] dst_addr_upper;
      logic [63:0] dst_addr_lower;
      logic [15:0] src_port_num;
      logic [15:0] dst_port_num;
      logic [63:0] timestamp;
   } req_word_type;

   typedef struct packed {
      logic                  flow_live;
      logic                  slot_touched;
      logic [SLOT_NUM_W-1:0] slot_number;
   } rsp_word_type;

   typedef struct packed {
      logic        ipv6;
      logic        tcp;
      logic [63:0] lo_upper;
      logic [63:0] lo_lower;
      logic [15:0] lo_port;
      logic [63:0] hi_upper;
      logic [63:0] hi_lower;
      logic [15:0] hi_port;
   } flow_key_type;

   // broadcast to every cell for the duration of a scan
   typedef struct packed {
      flow_key_type key;
      logic         query;
      logic [63:0]  now;
      logic [31:0]  tcp_expiry;
      logic [31:0]  udp_expiry;
   } scan_ctx_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic             active;
      logic             matched;
      logic             match_exp;
      logic [IDX_W-1:0] match_idx;
      logic             have;
      logic [IDX_W-1:0] victim;
      logic             victim_valid;
      logic [63:0]      victim_seen;
   } scan_carry_type;

   typedef enum logic [1:0] {
      WR_CLAIM,
      WR_REFRESH,
      WR_INVALIDATE
   } wr_kind_type;

   typedef struct packed {
      logic             en;
      wr_kind_type      kind;
      logic [IDX_W-1:0] idx;
      flow_key_type     key;
      logic [63:0]      now;
   } slot_wr_type;

endpackage

FILE: rtl/core/fct_cell.sv
module fct_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [fct_pkg::IDX_W-1:0]  cell_index,
   input  fct_pkg::scan_ctx_type      ctx,
   input  fct_pkg::scan_carry_type    carry_in,
   output fct_pkg::scan_carry_type    carry_out,
   input  fct_pkg::slot_wr_type       wr
);

   logic                   valid_ff, valid_in;
   fct_pkg::flow_key_type  key_ff, key_in;
   logic [63:0]            seen_ff, seen_in;
   fct_pkg::scan_carry_type carry_ff, carry_in_next;

   logic [63:0] timeout;
   logic [63:0] deadline;
   logic        expired;
   logic        match;
   logic        hit_wr;

   assign timeout  = {32'b0, key_ff.tcp ? ctx.tcp_expiry : ctx.udp_expiry};
   assign deadline = seen_ff + timeout;
   assign expired  = ctx.now > deadline;
   assign match    = valid_ff && (key_ff == ctx.key);
   assign hit_wr   = wr.en && (wr.idx == cell_index);

   always_comb begin
      carry_in_next = carry_in;
      if (carry_in.active && !carry_in.matched) begin
         if (match) begin
            carry_in_next.matched   = 1'b1;
            carry_in_next.match_exp = expired;
            carry_in_next.match_idx = cell_index;
         end else if (!ctx.query) begin
            if (!valid_ff || expired) begin
               if (!carry_in.have || !valid_ff) begin
                  carry_in_next.have         = 1'b1;
                  carry_in_next.victim       = cell_index;
                  carry_in_next.victim_valid = valid_ff;
                  carry_in_next.victim_seen  = seen_ff;
               end
            end else if (carry_in.have && carry_in.victim_valid &&
                         seen_ff < carry_in.victim_seen) begin
               carry_in_next.victim       = cell_index;
               carry_in_next.victim_valid = 1'b1;
               carry_in_next.victim_seen  = seen_ff;
            end else if (!carry_in.have) begin
               carry_in_next.have         = 1'b1;
               carry_in_next.victim       = cell_index;
               carry_in_next.victim_valid = 1'b1;
               carry_in_next.victim_seen  = seen_ff;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      seen_in  = seen_ff;
      if (hit_wr) begin
         case (wr.kind)
            fct_pkg::WR_CLAIM: begin
               valid_in = 1'b1;
               key_in   = wr.key;
               seen_in  = wr.now;
            end
            fct_pkg::WR_REFRESH: begin
               seen_in = wr.now;
            end
            fct_pkg::WR_INVALIDATE: begin
               valid_in = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         carry_ff.active <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         carry_ff.active <= carry_in_next.active;
      end
      key_ff                <= key_in;
      seen_ff               <= seen_in;
      carry_ff.matched      <= carry_in_next.matched;
      carry_ff.match_exp    <= carry_in_next.match_exp;
      carry_ff.match_idx    <= carry_in_next.match_idx;
      carry_ff.have         <= carry_in_next.have;
      carry_ff.victim       <= carry_in_next.victim;
      carry_ff.victim_valid <= carry_in_next.victim_valid;
      carry_ff.victim_seen  <= carry_in_next.victim_seen;
   end

   assign carry_out = carry_ff;

endmodule

FILE: rtl/core/flow_connection_tracker_core.sv
// Connection tracking flow table with idle expiry and least-recently-seen
// eviction.
// req_ channel: one word per packet with the parsed flow key, mode and time.
// rsp_ channel: one word per request (flow_live, slot_touched, slot_number).
// csr_ port: APB-style, tcp_idle_timeout at 0x0, udp_idle_timeout at 0x4.
// The table is a row of TABLE_ENTRIES cells, one slot each. A scan token
// walks the row one cell per cycle through the register in each cell;
// the end of the walk goes into fin_ff and then the output register. An
// untracked request skips the walk. One request is in flight at a time,
// so a new request is not taken until the previous one has finished.
// req_stall is high while a request is in flight. A finished result sits in
// the output register; if rsp_stall holds it, the next request may still be
// accepted and scanned, and its table update and result wait until the
// output register frees.
// Reset (synchronous) invalidates every slot at once and zeroes both
// timeouts; no clearing pass is needed.
module flow_connection_tracker_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fct_pkg::req_word_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fct_pkg::rsp_word_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] tcp_to_ff, udp_to_ff;
   fct_pkg::scan_ctx_type   ctx_ff, ctx_in;
   logic                    tracked_ff, tracked_in;
   logic                    launch_ff, launch_in;
   fct_pkg::scan_carry_type fin_ff, fin_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fct_pkg::rsp_word_type   rsp_ff, rsp_in;

   fct_pkg::scan_carry_type chain [fct_pkg::TABLE_ENTRIES+1];
   fct_pkg::slot_wr_type    wr;
   fct_pkg::scan_carry_type start;

   logic req_acc, csr_wr, tracked_req, src_low, out_free;
   logic [63:0] su, sl, du, dl;
   fct_pkg::flow_key_type key_req;
   logic [fct_pkg::IDX_W+fct_pkg::SLOT_NUM_W-1:0] match_wide, victim_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == fct_pkg::REG_UDP_TIMEOUT) ? udp_to_ff : tcp_to_ff;

   assign tracked_req = req_data.trackable &&
                        (req_data.l4_protocol == fct_pkg::PROTO_TCP ||
                         req_data.l4_protocol == fct_pkg::PROTO_UDP);

   // IPv4 keeps only the top 32 address bits
   assign su = req_data.is_ipv6 ? req_data.src_addr_upper
                                : {req_data.src_addr_upper[63:32], 32'b0};
   assign du = req_data.is_ipv6 ? req_data.dst_addr_upper
                                : {req_data.dst_addr_upper[63:32], 32'b0};
   assign sl = req_data.is_ipv6 ? req_data.src_addr_lower : 64'b0;
   assign dl = req_data.is_ipv6 ? req_data.dst_addr_lower : 64'b0;
   assign src_low = {su, sl, req_data.src_port_num} <= {du, dl, req_data.dst_port_num};

   always_comb begin
      key_req.ipv6 = req_data.is_ipv6;
      key_req.tcp  = (req_data.l4_protocol == fct_pkg::PROTO_TCP);
      if (src_low) begin
         key_req.lo_upper = su;
         key_req.lo_lower = sl;
         key_req.lo_port  = req_data.src_port_num;
         key_req.hi_upper = du;
         key_req.hi_lower = dl;
         key_req.hi_port  = req_data.dst_port_num;
      end else begin
         key_req.lo_upper = du;
         key_req.lo_lower = dl;
         key_req.lo_port  = req_data.dst_port_num;
         key_req.hi_upper = su;
         key_req.hi_lower = sl;
         key_req.hi_port  = req_data.src_port_num;
      end
   end

   // token enters cell 0 the cycle after accept, once ctx_ff holds the key
   assign launch_in = req_acc && tracked_req;

   always_comb begin
      start        = '0;
      start.active = launch_ff;
   end

   assign chain[0] = start;

   for (genvar g = 0; g < fct_pkg::TABLE_ENTRIES; g++) begin : g_cell
      fct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (fct_pkg::IDX_W'(g)),
         .ctx        (ctx_ff),
         .carry_in   (chain[g]),
         .carry_out  (chain[g+1]),
         .wr         (wr)
      );
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign match_wide  = {{fct_pkg::SLOT_NUM_W{1'b0}}, fin_ff.match_idx};
   assign victim_wide = {{fct_pkg::SLOT_NUM_W{1'b0}}, fin_ff.victim};

   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      tracked_in   = tracked_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr           = '0;
      wr.kind      = fct_pkg::WR_CLAIM;
      wr.key       = ctx_ff.key;
      wr.now       = ctx_ff.now;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ctx_in.key        = key_req;
               ctx_in.query      = req_data.mode;
               ctx_in.now        = req_data.timestamp;
               ctx_in.tcp_expiry = tcp_to_ff;
               ctx_in.udp_expiry = udp_to_ff;
               tracked_in        = tracked_req;
               state_in          = tracked_req ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            if (chain[fct_pkg::TABLE_ENTRIES].active) begin
               fin_in   = chain[fct_pkg::TABLE_ENTRIES];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (tracked_ff) begin
                  if (fin_ff.matched) begin
                     rsp_in.slot_touched = 1'b1;
                     rsp_in.slot_number  = match_wide[fct_pkg::SLOT_NUM_W-1:0];
                     wr.en  = 1'b1;
                     wr.idx = fin_ff.match_idx;
                     if (ctx_ff.query && fin_ff.match_exp) begin
                        wr.kind = fct_pkg::WR_INVALIDATE;
                     end else begin
                        wr.kind = fct_pkg::WR_REFRESH;
                        rsp_in.flow_live = ctx_ff.query;
                     end
                  end else if (!ctx_ff.query) begin
                     rsp_in.slot_touched = 1'b1;
                     rsp_in.slot_number  = victim_wide[fct_pkg::SLOT_NUM_W-1:0];
                     wr.en   = 1'b1;
                     wr.kind = fct_pkg::WR_CLAIM;
                     wr.idx  = fin_ff.victim;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         launch_ff    <= 1'b0;
         tcp_to_ff    <= '0;
         udp_to_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         launch_ff    <= launch_in;
         if (csr_wr && csr_paddr[2] == fct_pkg::REG_TCP_TIMEOUT) tcp_to_ff <= csr_pwdata;
         if (csr_wr && csr_paddr[2] == fct_pkg::REG_UDP_TIMEOUT) udp_to_ff <= csr_pwdata;
      end
      ctx_ff     <= ctx_in;
      tracked_ff <= tracked_in;
      fin_ff     <= fin_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_wr_in_fin: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> state_ff == ST_FIN)
      else $error("slot write outside finish");
   a_token_end: assert property (@(posedge clock) disable iff (reset)
      chain[fct_pkg::TABLE_ENTRIES].active |-> state_ff == ST_SCAN)
      else $error("scan token ends outside scan");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != ST_IDLE)
      else $error("accepted word left block idle");
   a_claim_record: assert property (@(posedge clock) disable iff (reset)
      (wr.en && wr.kind == fct_pkg::WR_CLAIM) |-> !ctx_ff.query)
      else $error("slot claimed in query mode");
`endif

endmodule
